/* hw/rtl/uxe_pkg.sv */
// ----------------------------------------------------------------------------
// uxe_pkg
// Types, constants and helper functions shared by the XML escape encoder.
// ----------------------------------------------------------------------------
package uxe_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CP_W        = 21;

    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3c;
    localparam logic [7:0] CH_GT   = 8'h3e;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_X    = 8'h78;
    localparam logic [7:0] CH_SEMI = 8'h3b;
    localparam logic [7:0] CH_A    = 8'h61;
    localparam logic [7:0] CH_M    = 8'h6d;
    localparam logic [7:0] CH_P    = 8'h70;
    localparam logic [7:0] CH_L    = 8'h6c;
    localparam logic [7:0] CH_G    = 8'h67;
    localparam logic [7:0] CH_T    = 8'h74;

    typedef enum logic [2:0] {
        MK_RAW,
        MK_AMP,
        MK_LT,
        MK_GT,
        MK_REF
    } msg_kind_t;

    typedef enum logic [1:0] {
        ST_DECIDE,
        ST_EMIT,
        ST_FINISH
    } back_state_t;

    typedef enum logic [1:0] {
        A_HOLD,
        A_RAW1,
        A_MSG
    } action_t;

    // One queued input byte with its sequence length class.
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic [2:0] slen;
    } item_t;

    // Output request from the back end to the output stage.
    typedef struct packed {
        logic       byte_v;
        logic       end_v;
        logic [7:0] data;
    } evt_t;

    typedef struct packed {
        logic pend_v;
        logic out_free;
    } ostat_t;

    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] r;
        if (b <= 8'h7f) begin
            r = 3'd1;
        end else if (b inside {[8'hc2:8'hdf]}) begin
            r = 3'd2;
        end else if (b inside {[8'he0:8'hef]}) begin
            r = 3'd3;
        end else if (b inside {[8'hf0:8'hf4]}) begin
            r = 3'd4;
        end else begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic is_cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic logic xml_ok(input logic [CP_W-1:0] w);
        return (w == 21'h9) || (w == 21'ha) || (w == 21'hd) ||
               (w >= 21'h20 && w <= 21'hd7ff) ||
               (w >= 21'he000 && w <= 21'hfffd) ||
               (w >= 21'h10000 && w <= 21'h10ffff);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10) begin
            r = 8'h30 + {4'd0, d};
        end else begin
            r = 8'h57 + {4'd0, d};
        end
        return r;
    endfunction

    // Hex digits needed for a value, at least one.
    function automatic logic [2:0] num_digits(input logic [CP_W-1:0] v);
        logic [2:0] r;
        if (v[20] != 1'b0) begin
            r = 3'd6;
        end else if (v[19:16] != 4'd0) begin
            r = 3'd5;
        end else if (v[15:12] != 4'd0) begin
            r = 3'd4;
        end else if (v[11:8] != 4'd0) begin
            r = 3'd3;
        end else if (v[7:4] != 4'd0) begin
            r = 3'd2;
        end else begin
            r = 3'd1;
        end
        return r;
    endfunction

endpackage

/* hw/rtl/uxe_front.sv */
// ----------------------------------------------------------------------------
// uxe_front
// Accepts input bytes, classifies their sequence length and queues them.
// ----------------------------------------------------------------------------
module uxe_front
    import uxe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       q_valid,
    output item_t      q_item,
    input  logic       q_pop
);

    item_t               mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg;
    logic [QCNT_W-1:0]   cnt_next;
    logic                push;
    item_t               new_item;

    assign in_stall = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.data = in_byte;
        new_item.eos  = end_of_stream;
        new_item.slen = seq_len(in_byte);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && q_pop) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= new_item;
        end
    end

endmodule

/* hw/rtl/uxe_back.sv */
// ----------------------------------------------------------------------------
// uxe_back
// Holds partial UTF-8 sequences, checks them and sequences the output bytes.
// ----------------------------------------------------------------------------
module uxe_back
    import uxe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   q_valid,
    input  item_t  q_item,
    output logic   q_pop,
    input  ostat_t ost,
    output evt_t   evt
);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [1:0]        hc_reg;
    logic [1:0]        hc_next;
    logic [7:0]        held_reg [3];
    logic [2:0]        hlen_reg;
    item_t             rp_reg [3];
    item_t             rp_next [3];
    logic [1:0]        rcnt_reg;
    logic [1:0]        rcnt_next;
    msg_kind_t         kind_reg;
    logic [7:0]        mseq_reg [4];
    logic [3:0]        mlen_reg;
    logic [CP_W-1:0]   mval_reg;
    logic [2:0]        mnd_reg;
    logic [3:0]        idx_reg;
    logic              final_reg;

    logic              from_rp;
    logic              src_v;
    item_t             src;
    logic [2:0]        n;
    logic [7:0]        seq [4];
    logic [CP_W-1:0]   cp;
    logic              ok;
    logic              malformed;
    action_t           act;
    logic              do_hold;
    logic [2:0]        hold_len;
    msg_kind_t         m_kind;
    logic [3:0]        m_len;
    logic [CP_W-1:0]   m_val;
    logic [2:0]        m_nd;
    item_t             rem [2];
    logic [1:0]        rem_cnt;
    item_t             mal [3];
    logic [1:0]        mal_cnt;
    logic              is_final;
    logic              can_ev;
    logic              need;
    logic              go;
    logic [7:0]        mchar;
    logic              emit_last;
    logic [2:0]        npos;
    logic [3:0]        nib;

    assign from_rp = (rcnt_reg != 2'd0);
    assign src_v   = from_rp || q_valid;
    assign src     = from_rp ? rp_reg[0] : q_item;
    assign can_ev  = ost.pend_v ? ost.out_free : 1'b1;

    // Classify the current byte against the held sequence.
    always_comb
    begin
        n      = {1'b0, hc_reg} + 3'd1;
        seq[0] = (hc_reg == 2'd0) ? src.data : held_reg[0];
        seq[1] = (hc_reg == 2'd1) ? src.data : ((hc_reg > 2'd1) ? held_reg[1] : 8'd0);
        seq[2] = (hc_reg == 2'd2) ? src.data : ((hc_reg > 2'd2) ? held_reg[2] : 8'd0);
        seq[3] = (hc_reg == 2'd3) ? src.data : 8'd0;

        case (hlen_reg)
            3'd2:
            begin
                ok = is_cont(seq[1]);
                cp = {10'd0, seq[0][4:0], seq[1][5:0]};
            end
            3'd3:
            begin
                ok = is_cont(seq[1]) && is_cont(seq[2]) &&
                     (seq[0] >= 8'he1 || seq[1] >= 8'ha0);
                cp = {5'd0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
            end
            default:
            begin
                ok = is_cont(seq[1]) && is_cont(seq[2]) && is_cont(seq[3]) &&
                     (seq[0] >= 8'hf1 || seq[1] >= 8'h90);
                cp = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
            end
        endcase

        act       = A_HOLD;
        malformed = 1'b0;
        do_hold   = 1'b0;
        hold_len  = src.slen;
        hc_next   = 2'd0;
        m_kind    = MK_RAW;
        m_len     = {1'b0, n};
        m_val     = {13'd0, src.data};

        if (hc_reg == 2'd0) begin
            if (src.data == CH_AMP) begin
                act    = A_MSG;
                m_kind = MK_AMP;
                m_len  = 4'd5;
            end else if (src.data == CH_LT) begin
                act    = A_MSG;
                m_kind = MK_LT;
                m_len  = 4'd4;
            end else if (src.data == CH_GT) begin
                act    = A_MSG;
                m_kind = MK_GT;
                m_len  = 4'd4;
            end else if (src.slen == 3'd0) begin
                act    = A_MSG;
                m_kind = MK_REF;
            end else if (src.slen == 3'd1) begin
                if (xml_ok({13'd0, src.data})) begin
                    act = A_RAW1;
                end else begin
                    act    = A_MSG;
                    m_kind = MK_REF;
                end
            end else if (src.eos) begin
                act = A_RAW1;
            end else begin
                do_hold = 1'b1;
                hc_next = 2'd1;
            end
        end else if (n < hlen_reg) begin
            if (src.eos) begin
                // Truncated sequence at end of stream leaves raw.
                act = A_MSG;
            end else begin
                do_hold  = 1'b1;
                hold_len = hlen_reg;
                hc_next  = n[1:0];
            end
        end else if (ok) begin
            act = A_MSG;
            if (!xml_ok(cp)) begin
                m_kind = MK_REF;
                m_val  = cp;
            end
        end else begin
            act       = A_MSG;
            malformed = 1'b1;
            m_kind    = MK_REF;
            m_val     = {13'd0, seq[0]};
        end

        m_nd = num_digits(m_val);
        if (m_kind == MK_REF) begin
            m_len = {1'b0, m_nd} + 4'd4;
        end
    end

    // Replay list: followers of a malformed sequence go ahead of what is left.
    always_comb
    begin
        rem[0]  = rp_reg[1];
        rem[1]  = rp_reg[2];
        rem_cnt = from_rp ? (rcnt_reg - 2'd1) : 2'd0;
        mal_cnt = n[1:0] - 2'd1;
        for (int k = 0; k < 3; k++) begin
            mal[k].data = seq[k+1];
            mal[k].eos  = src.eos && (k == int'(n) - 2);
            mal[k].slen = seq_len(seq[k+1]);
        end
        for (int k = 0; k < 3; k++) begin
            if (!malformed) begin
                rp_next[k] = (k < 2) ? rem[k] : rp_reg[2];
            end else if (2'(k) < mal_cnt) begin
                rp_next[k] = mal[k];
            end else begin
                rp_next[k] = rem[1'(2'(k) - mal_cnt)];
            end
        end
        rcnt_next = malformed ? (mal_cnt + rem_cnt) : rem_cnt;
        is_final  = (rcnt_next == 2'd0);
    end

    // Character at the current position of the pending message.
    always_comb
    begin
        npos = 3'({1'b0, mnd_reg} + 4'd2 - idx_reg);
        case (npos)
            3'd0:    nib = mval_reg[3:0];
            3'd1:    nib = mval_reg[7:4];
            3'd2:    nib = mval_reg[11:8];
            3'd3:    nib = mval_reg[15:12];
            3'd4:    nib = mval_reg[19:16];
            default: nib = {3'd0, mval_reg[20]};
        endcase
        mchar = CH_SEMI;
        case (kind_reg)
            MK_RAW:
            begin
                mchar = mseq_reg[idx_reg[1:0]];
            end
            MK_AMP:
            begin
                case (idx_reg)
                    4'd0:    mchar = CH_AMP;
                    4'd1:    mchar = CH_A;
                    4'd2:    mchar = CH_M;
                    4'd3:    mchar = CH_P;
                    default: mchar = CH_SEMI;
                endcase
            end
            MK_LT, MK_GT:
            begin
                case (idx_reg)
                    4'd0:    mchar = CH_AMP;
                    4'd1:    mchar = (kind_reg == MK_LT) ? CH_L : CH_G;
                    4'd2:    mchar = CH_T;
                    default: mchar = CH_SEMI;
                endcase
            end
            MK_REF:
            begin
                if (idx_reg == 4'd0) begin
                    mchar = CH_AMP;
                end else if (idx_reg == 4'd1) begin
                    mchar = CH_HASH;
                end else if (idx_reg == 4'd2) begin
                    mchar = CH_X;
                end else if (idx_reg == mlen_reg - 4'd1) begin
                    mchar = CH_SEMI;
                end else begin
                    mchar = hex_char(nib);
                end
            end
            default:
            begin
                mchar = CH_SEMI;
            end
        endcase
        emit_last = (idx_reg == mlen_reg - 4'd1);
    end

    always_comb
    begin
        case (act)
            A_HOLD:  need = is_final ? can_ev : 1'b1;
            A_RAW1:  need = (is_final && !ost.pend_v) ? ost.out_free : can_ev;
            default: need = 1'b1;
        endcase
        go    = (state_reg == ST_DECIDE) && src_v && need;
        q_pop = go && !from_rp;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_DECIDE:
            begin
                if (go) begin
                    if (act == A_MSG) begin
                        state_next = ST_EMIT;
                    end else if (act == A_RAW1 && is_final && ost.pend_v) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_EMIT:
            begin
                if (can_ev && emit_last) begin
                    state_next = final_reg ? ST_FINISH : ST_DECIDE;
                end
            end
            ST_FINISH:
            begin
                if (can_ev) begin
                    state_next = ST_DECIDE;
                end
            end
            default:
            begin
                state_next = ST_DECIDE;
            end
        endcase
    end

    // Output requests.
    always_comb
    begin
        evt.byte_v = 1'b0;
        evt.end_v  = 1'b0;
        evt.data   = src.data;
        case (state_reg)
            ST_DECIDE:
            begin
                if (go && act == A_RAW1) begin
                    evt.byte_v = 1'b1;
                    evt.end_v  = is_final && !ost.pend_v;
                end else if (go && act == A_HOLD) begin
                    evt.end_v = is_final;
                end
            end
            ST_EMIT:
            begin
                evt.byte_v = can_ev;
                evt.data   = mchar;
            end
            ST_FINISH:
            begin
                evt.end_v = can_ev;
            end
            default:
            begin
                evt.byte_v = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_DECIDE;
            hc_reg    <= 2'd0;
            rcnt_reg  <= 2'd0;
            idx_reg   <= 4'd0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (go) begin
                hc_reg    <= hc_next;
                rcnt_reg  <= rcnt_next;
                idx_reg   <= 4'd0;
                final_reg <= is_final;
            end else if (state_reg == ST_EMIT && can_ev) begin
                idx_reg <= idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go) begin
            if (do_hold) begin
                held_reg[hc_reg] <= src.data;
                hlen_reg         <= hold_len;
            end
            for (int k = 0; k < 3; k++) begin
                rp_reg[k] <= rp_next[k];
            end
            for (int k = 0; k < 4; k++) begin
                mseq_reg[k] <= seq[k];
            end
            kind_reg <= m_kind;
            mlen_reg <= m_len;
            mval_reg <= m_val;
            mnd_reg  <= m_nd;
        end
    end

endmodule

/* hw/rtl/uxe_out.sv */
// ----------------------------------------------------------------------------
// uxe_out
// Output stage: keeps one byte back so the last byte of a request can be
// marked, and drives the registered output channel.
// ----------------------------------------------------------------------------
module uxe_out
    import uxe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  evt_t       evt,
    output ostat_t     ost,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic       pend_v_reg;
    logic       pend_v_next;
    logic [7:0] pend_reg;
    logic       out_v_reg;
    logic       out_v_next;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;
    logic       out_last_reg;
    logic       out_last_next;

    assign ost.pend_v   = pend_v_reg;
    assign ost.out_free = !out_v_reg || !out_stall;
    assign out_valid    = out_v_reg;
    assign out_byte     = out_data_reg;
    assign last_of_run  = out_last_reg;

    always_comb
    begin
        pend_v_next   = pend_v_reg;
        out_v_next    = out_v_reg && out_stall;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        if (evt.byte_v && evt.end_v) begin
            out_v_next    = 1'b1;
            out_data_next = evt.data;
            out_last_next = 1'b1;
        end else if (evt.byte_v) begin
            pend_v_next = 1'b1;
            if (pend_v_reg) begin
                out_v_next    = 1'b1;
                out_data_next = pend_reg;
                out_last_next = 1'b0;
            end
        end else if (evt.end_v && pend_v_reg) begin
            pend_v_next   = 1'b0;
            out_v_next    = 1'b1;
            out_data_next = pend_reg;
            out_last_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end else begin
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.byte_v && !evt.end_v) begin
            pend_reg <= evt.data;
        end
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

endmodule

/* hw/rtl/utf8_xml_escape_encoder.sv */
// ----------------------------------------------------------------------------
// utf8_xml_escape_encoder
// UTF-8 to XML-safe byte stream escaper, built from a queueing front end,
// a sequencing back end and a registered output stage.
// ----------------------------------------------------------------------------
// Pacing: a plain byte needs no setup; an entity, a reference or a completed
// multi-byte sequence is set up first and then sent one output byte at a time as
// the output takes them, with a final step to mark the last byte when the run ends,
// all paced by the back end's single sequencer.
// Reset: asynchronous, active low; clears the queue, held count and output.
module utf8_xml_escape_encoder
    import uxe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    logic   q_valid;
    item_t  q_item;
    logic   q_pop;
    evt_t   evt;
    ostat_t ost;

    uxe_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    uxe_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .ost     (ost),
        .evt     (evt)
    );

    uxe_out u_out (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .ost         (ost),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run)
    );

endmodule

/* tb/utf8_xml_escape_encoder_tb.sv */
// ----------------------------------------------------------------------------
// utf8_xml_escape_encoder_tb
// Drives byte requests into the XML escape encoder, predicts the escaped
// output stream with a behavioral escaper and checks every output byte.
// ----------------------------------------------------------------------------
module utf8_xml_escape_encoder_tb;
    import uxe_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_stream;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       last_of_run;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } esc_byte_t;

    esc_byte_t  escaped_q[$];
    esc_byte_t  run_bytes[$];
    logic [7:0] held[3];
    int unsigned held_n;
    int         errors;
    bit         sink_idle_en;
    bit         sink_hold;
    int         sink_cnt;

    utf8_xml_escape_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_stream(end_of_stream),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic void put_raw(input logic [7:0] b);
        esc_byte_t e;
        e.data = b;
        e.last = 1'b0;
        run_bytes.push_back(e);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put_raw(s[i]);
        end
    endfunction

    function automatic void put_charref(input logic [20:0] v);
        int sh;
        logic [3:0] d;
        sh = 20;
        put_str("&#x");
        while (sh > 0 && ((v >> sh) & 21'hf) == 0)
        begin
            sh -= 4;
        end
        for (; sh >= 0; sh -= 4)
        begin
            d = 4'((v >> sh) & 21'hf);
            put_raw(d < 10 ? 8'h30 + d : 8'h57 + d);
        end
        put_raw(CH_SEMI);
    endfunction

    function automatic int lead_width(input logic [7:0] b);
        if (b <= 8'h7f) return 1;
        if (b >= 8'hc2 && b <= 8'hdf) return 2;
        if (b >= 8'he0 && b <= 8'hef) return 3;
        if (b >= 8'hf0 && b <= 8'hf4) return 4;
        return 0;
    endfunction

    function automatic bit char_allowed(input logic [20:0] w);
        return w == 9 || w == 10 || w == 13 || (w >= 21'h20 && w <= 21'hd7ff) ||
               (w >= 21'he000 && w <= 21'hfffd) || (w >= 21'h10000 && w <= 21'h10ffff);
    endfunction

    function automatic bit cont(input logic [7:0] b);
        return b[7:6] == 2'b10;
    endfunction

    function automatic void escape_byte(input logic [7:0] b, input bit eos);
        logic [7:0] s[4];
        int n, w;
        bit ok;
        logic [20:0] cp;
        if (held_n == 0)
        begin
            if (b == CH_AMP) begin put_str("&amp;"); return; end
            if (b == CH_LT) begin put_str("&lt;"); return; end
            if (b == CH_GT) begin put_str("&gt;"); return; end
            w = lead_width(b);
            if (w == 0) begin put_charref({13'd0, b}); return; end
            if (w == 1)
            begin
                if (char_allowed({13'd0, b})) put_raw(b); else put_charref({13'd0, b});
                return;
            end
            if (eos) begin put_raw(b); return; end
            held[0] = b;
            held_n = 1;
            return;
        end
        n = held_n;
        for (int i = 0; i < n; i++) s[i] = held[i];
        s[n] = b;
        n++;
        w = lead_width(s[0]);
        if (w < 2) w = 2;
        if (n < w)
        begin
            if (eos)
            begin
                for (int i = 0; i < n; i++) put_raw(s[i]);
                held_n = 0;
            end
            else
            begin
                held[n-1] = b;
                held_n = n;
            end
            return;
        end
        held_n = 0;
        if (w == 2)
        begin
            ok = cont(s[1]);
            cp = {10'd0, s[0][4:0], s[1][5:0]};
        end
        else if (w == 3)
        begin
            ok = cont(s[1]) && cont(s[2]) && (s[0] >= 8'he1 || s[1] >= 8'ha0);
            cp = {5'd0, s[0][3:0], s[1][5:0], s[2][5:0]};
        end
        else
        begin
            ok = cont(s[1]) && cont(s[2]) && cont(s[3]) &&
                 (s[0] >= 8'hf1 || s[1] >= 8'h90);
            cp = {s[0][2:0], s[1][5:0], s[2][5:0], s[3][5:0]};
        end
        if (ok)
        begin
            if (char_allowed(cp))
                for (int i = 0; i < n; i++) put_raw(s[i]);
            else
                put_charref(cp);
            return;
        end
        put_charref({13'd0, s[0]});
        for (int i = 1; i < n; i++)
        begin
            escape_byte(s[i], eos && i == n - 1);
        end
    endfunction

    function automatic void predict_escape(input logic [7:0] b, input bit eos);
        run_bytes = {};
        escape_byte(b, eos);
        if (run_bytes.size() > 0) run_bytes[run_bytes.size()-1].last = 1'b1;
        foreach (run_bytes[i]) escaped_q.push_back(run_bytes[i]);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit eos, input bit gaps);
        int gap;
        if (gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= b;
        end_of_stream <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_escape(b, eos);
    endtask

    task automatic send_idle();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Output checker.
    always @(posedge clk)
    begin
        esc_byte_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (escaped_q.size() == 0)
            begin
                $error("unexpected out_byte %h", out_byte);
                errors++;
            end
            else
            begin
                e = escaped_q.pop_front();
                if (out_byte !== e.data)
                begin
                    $error("out_byte expected %h actual %h", e.data, out_byte);
                    errors++;
                end
                if (last_of_run !== e.last)
                begin
                    $error("last_of_run expected %b actual %b", e.last, last_of_run);
                    errors++;
                end
            end
        end
    end

    // Receiver stall bursts at random while sink_idle_en is set.
    always @(posedge clk)
    begin
        if (sink_hold)
            out_stall <= 1'b1;
        else if (!sink_idle_en)
            out_stall <= 1'b0;
        else if (sink_cnt != 0)
        begin
            out_stall <= 1'b1;
            sink_cnt = sink_cnt - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            sink_cnt = $urandom_range(0, 9);
        end
        else
            out_stall <= 1'b0;
    end

    task automatic test_directed();
        logic [7:0] seq[$];
        seq = {8'h41, CH_AMP, CH_LT, CH_GT, 8'h00, 8'h09, 8'h7f, 8'h80, 8'hff, 8'hc0,
               8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hed, 8'ha0, 8'h80,
               8'hf4, 8'h90, 8'h80, 8'h80, 8'hef, 8'hbf, 8'hbf};
        foreach (seq[i]) send_byte(seq[i], 0, 0);
        // Malformed sequences reprocess the followers, and end of stream flushes.
        send_byte(8'he0, 0, 0);
        send_byte(8'h80, 0, 0);
        send_byte(8'h26, 1, 0);
        send_byte(8'hf0, 0, 0);
        send_byte(8'h9f, 0, 0);
        send_byte(8'h3c, 1, 0);
        send_byte(8'hc2, 1, 0);
        send_byte(8'hf0, 0, 0);
        send_byte(8'h80, 0, 0);
        send_byte(8'hc3, 1, 0);
    endtask

    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 30; i++) send_byte(i[0] ? CH_AMP : 8'h01, 0, 0);
        join
    endtask

    task automatic send_random(input int count, input bit gaps);
        logic [7:0] b;
        int w, k;
        k = 0;
        while (k < count)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                // Mostly well formed sequences with random content.
                case ($urandom_range(0, 2))
                    0: b = 8'(($urandom_range(0, 29)) + 8'hc2);
                    1: b = 8'($urandom_range(8'he0, 8'hef));
                    default: b = 8'($urandom_range(8'hf0, 8'hf4));
                endcase
                w = lead_width(b);
                send_byte(b, 0, gaps);
                for (int j = 1; j < w; j++)
                begin
                    send_byte($urandom_range(0, 9) == 0 ? 8'($urandom) :
                              8'($urandom_range(8'h80, 8'hbf)),
                              $urandom_range(0, 40) == 0, gaps);
                end
                k += w;
            end
            else
            begin
                send_byte(8'($urandom), $urandom_range(0, 30) == 0, gaps);
                k++;
            end
        end
    endtask

    initial
    begin
        int wait_n;
        errors        = 0;
        held_n        = 0;
        sink_idle_en  = 1'b0;
        sink_hold     = 1'b0;
        sink_cnt      = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_byte       = 8'h00;
        end_of_stream = 1'b0;
        out_stall     = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        sink_idle_en = 1'b1;
        test_backpressure();
        send_random(300, 1);
        sink_idle_en = 1'b0;
        send_random(100, 0);
        send_byte(8'h41, 1, 0);
        send_idle();
        wait_n = 0;
        while (escaped_q.size() != 0 && wait_n < 10000)
        begin
            @(posedge clk);
            wait_n++;
        end
        repeat (20) @(posedge clk);
        if (errors == 0 && escaped_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/uxe_pkg.sv
hw/rtl/uxe_front.sv
hw/rtl/uxe_back.sv
hw/rtl/uxe_out.sv
hw/rtl/utf8_xml_escape_encoder.sv
tb/utf8_xml_escape_encoder_tb.sv
